// ===== hw/rtl/dtsp_pkg.sv =====
// Shared types and constants for the date/time string parser.
`timescale 1ns / 1ps

package dtsp_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned NUM_W   = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned LEN_W   = 3;
    localparam int unsigned FIELD_W = 3;
    localparam int unsigned TOK_DEPTH = 4;

    localparam logic [CHAR_W-1:0] CHAR_END   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    // Token order within one string
    localparam logic [FIELD_W-1:0] FIELD_WEEKDAY = 3'd0;
    localparam logic [FIELD_W-1:0] FIELD_MONTH   = 3'd1;
    localparam logic [FIELD_W-1:0] FIELD_DAY     = 3'd2;
    localparam logic [FIELD_W-1:0] FIELD_HOURS   = 3'd3;
    localparam logic [FIELD_W-1:0] FIELD_MINUTES = 3'd4;
    localparam logic [FIELD_W-1:0] FIELD_SECONDS = 3'd5;
    localparam logic [FIELD_W-1:0] FIELD_YEAR    = 3'd6;
    localparam logic [FIELD_W-1:0] FIELD_LAST    = 3'd7;

    localparam logic [LEN_W-1:0] MONTH_NAME_LEN = 3'd3;
    localparam logic [LEN_W-1:0] TOKEN_FULL_LEN = 3'd4;

    localparam logic [4*CHAR_W-1:0] EPOCH_YEAR = "1970";

    localparam logic [3*CHAR_W-1:0] MONTH_NAMES [12] = '{
        "Jan", "Feb", "Mar", "Apr", "May", "Jun",
        "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"
    };

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [NUM_W-1:0]  t_num;

    typedef struct packed {
        logic [MONTH_W-1:0] month;
        t_num               day;
        t_num               hours;
        t_num               minutes;
        t_num               seconds;
        t_num               year;
    } t_result;

    typedef struct packed {
        logic  valid;
        t_char char_code;
    } t_step;

    typedef struct packed {
        logic    valid;
        t_result fields;
    } t_emit;

    // Month number 1..12 from a three-letter name, 0 when nothing matches
    function automatic logic [MONTH_W-1:0] month_code(input logic [3*CHAR_W-1:0] name);
        logic [MONTH_W-1:0] code;
        code = '0;
        for (int m = 0; m < 12; m++) begin
            if (name == MONTH_NAMES[m]) begin
                code = MONTH_W'(m + 1);
            end
        end
        return code;
    endfunction

endpackage

// ===== hw/rtl/dtsp_char_if.sv =====
// Character input channel: valid/ready with one byte of payload.
`timescale 1ns / 1ps

interface dtsp_char_if;
    logic        valid;
    logic        ready;
    logic [7:0]  char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

// ===== hw/rtl/dtsp_result_if.sv =====
// Result channel: valid/ready with the parsed date fields.
`timescale 1ns / 1ps

interface dtsp_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  month;
    logic [13:0] day;
    logic [13:0] hours;
    logic [13:0] minutes;
    logic [13:0] seconds;
    logic [13:0] year;

    modport source (output valid, output month, output day, output hours,
                    output minutes, output seconds, output year, input ready);
    modport sink   (input valid, input month, input day, input hours,
                    input minutes, input seconds, input year, output ready);
endinterface

// ===== hw/rtl/dtsp_lead_digits.sv =====
// Decimal value of the leading digits of a token of up to four characters.
`timescale 1ns / 1ps

module dtsp_lead_digits (
    input  dtsp_pkg::t_char                i_chars [dtsp_pkg::TOK_DEPTH],
    input  logic [dtsp_pkg::LEN_W-1:0]     i_len,
    output dtsp_pkg::t_num                 o_value
);

    always_comb begin
        dtsp_pkg::t_num v;
        logic           stop;
        v    = '0;
        stop = 1'b0;
        for (int i = 0; i < dtsp_pkg::TOK_DEPTH; i++) begin
            if (!stop && (i_len > dtsp_pkg::LEN_W'(i)) &&
                (i_chars[i] >= dtsp_pkg::CHAR_ZERO) &&
                (i_chars[i] <= dtsp_pkg::CHAR_NINE)) begin
                // times ten as shift and add, then add the digit
                v = (v << 3) + (v << 1)
                    + dtsp_pkg::NUM_W'(i_chars[i] - dtsp_pkg::CHAR_ZERO);
            end else begin
                stop = 1'b1;
            end
        end
        o_value = v;
    end

endmodule

// ===== hw/rtl/dtsp_token_parse.sv =====
// Token store and field state; closes tokens and builds the result on the end byte.
`timescale 1ns / 1ps

module dtsp_token_parse (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dtsp_pkg::t_step i_step,
    output dtsp_pkg::t_emit o_emit
);

    dtsp_pkg::t_char               r_chars [dtsp_pkg::TOK_DEPTH];
    logic [dtsp_pkg::LEN_W-1:0]    r_len;
    logic [dtsp_pkg::FIELD_W-1:0]  r_field;
    dtsp_pkg::t_result             r_vals;
    logic                          r_rejected;

    dtsp_pkg::t_result             n_vals;
    logic                          n_rejected;

    logic           is_delim;
    logic           close_tok;
    logic           store_tok;
    logic           end_byte;
    logic           is_epoch;
    dtsp_pkg::t_num lead_value;

    dtsp_lead_digits u_lead (
        .i_chars (r_chars),
        .i_len   (r_len),
        .o_value (lead_value)
    );

    // A full token is closed by the next character, which is dropped
    assign is_delim  = (i_step.char_code == dtsp_pkg::CHAR_SPACE) ||
                       (i_step.char_code == dtsp_pkg::CHAR_COLON) ||
                       (i_step.char_code == dtsp_pkg::CHAR_END)   ||
                       (r_len >= dtsp_pkg::TOKEN_FULL_LEN);
    assign close_tok = i_step.valid && is_delim;
    assign store_tok = i_step.valid && !is_delim;
    assign end_byte  = i_step.valid && (i_step.char_code == dtsp_pkg::CHAR_END);
    assign is_epoch  = (r_len == dtsp_pkg::TOKEN_FULL_LEN) &&
                       ({r_chars[0], r_chars[1], r_chars[2], r_chars[3]} ==
                        dtsp_pkg::EPOCH_YEAR);

    always_comb begin
        n_vals     = r_vals;
        n_rejected = r_rejected;
        if (close_tok) begin
            case (r_field)
                dtsp_pkg::FIELD_MONTH: begin
                    n_vals.month = (r_len == dtsp_pkg::MONTH_NAME_LEN) ?
                        dtsp_pkg::month_code({r_chars[0], r_chars[1], r_chars[2]}) : '0;
                end
                dtsp_pkg::FIELD_DAY:     n_vals.day     = lead_value;
                dtsp_pkg::FIELD_HOURS:   n_vals.hours   = lead_value;
                dtsp_pkg::FIELD_MINUTES: n_vals.minutes = lead_value;
                dtsp_pkg::FIELD_SECONDS: n_vals.seconds = lead_value;
                dtsp_pkg::FIELD_YEAR: begin
                    if (is_epoch) begin
                        n_rejected = 1'b1;
                    end else begin
                        n_vals.year = lead_value;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_emit.valid  = end_byte && !n_rejected;
    assign o_emit.fields = n_vals;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_field    <= dtsp_pkg::FIELD_WEEKDAY;
            r_vals     <= '0;
            r_rejected <= 1'b0;
        end else if (end_byte) begin
            // clear everything for the next string
            r_len      <= '0;
            r_field    <= dtsp_pkg::FIELD_WEEKDAY;
            r_vals     <= '0;
            r_rejected <= 1'b0;
        end else if (close_tok) begin
            r_len      <= '0;
            r_vals     <= n_vals;
            r_rejected <= n_rejected;
            if (r_field != dtsp_pkg::FIELD_LAST) begin
                r_field <= r_field + 1'b1;
            end
        end else if (store_tok) begin
            r_len <= r_len + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_tok) begin
            r_chars[r_len[1:0]] <= i_step.char_code;
        end
    end

endmodule

// ===== hw/rtl/date_time_string_parser_unit.sv =====
// Top level of the date/time string parser: input register, parser, result register.
//
//  channel   | dir | payload                                   | handshake
//  i_char    | in  | char_code[7:0]                            | valid/ready
//  o_result  | out | month[3:0] day hours minutes seconds year | valid/ready
//
// One character per cycle sustained; a character is held in the input register and is
// then folded into the token state.
// A result loads into the output register on the same edge that folds its end byte
// into the token state.
// Reset (i_rst_n low, synchronous) clears token length, field state and both valids.
// The input register only waits when it holds an end byte and the output register is
// still full; other characters keep moving.
`timescale 1ns / 1ps

module date_time_string_parser_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dtsp_char_if.sink     i_char,
    dtsp_result_if.source o_result
);

    logic              r_in_valid;
    dtsp_pkg::t_char   r_in_char;
    logic              r_out_valid;
    dtsp_pkg::t_result r_out;

    logic              out_free;
    logic              proc;
    logic              load_out;
    dtsp_pkg::t_step   step;
    dtsp_pkg::t_emit   emit;

    assign out_free = !r_out_valid || o_result.ready;
    // Non-end characters never produce a transaction, so they never wait
    assign proc     = r_in_valid && (out_free || (r_in_char != dtsp_pkg::CHAR_END));
    assign i_char.ready = !r_in_valid || proc;

    assign step.valid     = proc;
    assign step.char_code = r_in_char;

    dtsp_token_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .o_emit  (emit)
    );

    assign load_out = emit.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.ready && i_char.valid) begin
            r_in_char <= i_char.char_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= emit.fields;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.month   = r_out.month;
    assign o_result.day     = r_out.day;
    assign o_result.hours   = r_out.hours;
    assign o_result.minutes = r_out.minutes;
    assign o_result.seconds = r_out.seconds;
    assign o_result.year    = r_out.year;

    // A held character must not be overwritten
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !proc) |=> (r_in_valid && $stable(r_in_char)))
        else $error("input register lost a held character");

    // A result only loads when the output register can take it
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> out_free)
        else $error("result loaded over an untaken transaction");

    // Only the end byte produces a result
    a_end_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (proc && (r_in_char == dtsp_pkg::CHAR_END)))
        else $error("result produced by a non-end character");

endmodule
